// ===== sv/ckf_pkg.sv =====
// Shared types, codes and saturating arithmetic helpers for the clock Kalman filter.
package ckf_pkg;

    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [2:0] STAT_INIT  = 3'd0;
    localparam logic [2:0] STAT_UPD   = 3'd1;
    localparam logic [2:0] STAT_SKIP  = 3'd2;
    localparam logic [2:0] STAT_QUERY = 3'd3;
    localparam logic [2:0] STAT_CLEAR = 3'd4;

    localparam logic [2:0] CFG_INIT_OFF_VAR = 3'd0;
    localparam logic [2:0] CFG_INIT_SKW_VAR = 3'd1;
    localparam logic [2:0] CFG_SKW_NOISE    = 3'd2;
    localparam logic [2:0] CFG_MEAS_VAR     = 3'd3;
    localparam logic [2:0] CFG_MIN_INTERVAL = 3'd4;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [63:0] dev_ts;
        logic signed [63:0] loc_ts;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [63:0] est_local;
        logic signed [63:0] offset;
        logic signed [63:0] skew;
    } t_out;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic               sh48;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic signed [63:0] n;
        logic signed [63:0] d;
    } t_div_req;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_OUT} t_state;
    typedef enum logic [1:0] {K_NONE, K_MUL, K_DIV} t_kind;

    typedef enum logic [4:0] {
        SP_DT, SP_CHK, SP_OFFP, SP_Q01, SP_Q00A, SP_Q00B, SP_Q11, SP_S,
        SP_K0, SP_K1, SP_R0, SP_R1, SP_OFFU, SP_SKW, SP_P00, SP_P01,
        SP_P10, SP_P11, SP_QEST0, SP_QEST1
    } t_step;

    function automatic logic signed [63:0] sat_addsub(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input logic sub);
        logic [64:0] s;
        begin
            s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
            if (s[64] != s[63]) begin
                sat_addsub = s[64] ? S64_MIN : S64_MAX;
            end else begin
                sat_addsub = s[63:0];
            end
        end
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        begin
            magnitude = v[63] ? (64'd0 - v) : v;
        end
    endfunction

    // Signed result from a magnitude whose upper part is flagged nonzero.
    function automatic logic signed [63:0] from_mag(input logic hi_nz,
                                                    input logic [63:0] lo,
                                                    input logic neg);
        begin
            if (hi_nz) begin
                from_mag = neg ? S64_MIN : S64_MAX;
            end else if (!neg) begin
                from_mag = lo[63] ? S64_MAX : lo;
            end else begin
                from_mag = lo[63] ? S64_MIN : (64'd0 - lo);
            end
        end
    endfunction

endpackage

// ===== sv/ckf_mul.sv =====
// Shared multiplier: 64x64 product from four 32x32 partials, then rounding shift and saturation.
module ckf_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ckf_pkg::t_mul_req  i_req,
    output logic               o_done,
    output logic signed [63:0] o_result
);
    import ckf_pkg::*;

    logic [63:0]  r_ua, r_ub;
    logic         r_neg, r_48, r_busy, r_done;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic signed [63:0] r_res;

    logic [31:0]  w_ah, w_bh;
    logic [63:0]  w_prod;
    logic [127:0] w_part, w_round, w_q;

    always_comb begin
        w_ah    = r_cnt[0] ? r_ua[63:32] : r_ua[31:0];
        w_bh    = r_cnt[1] ? r_ub[63:32] : r_ub[31:0];
        w_prod  = w_ah * w_bh;
        w_part  = {64'd0, w_prod} << (7'd32 * ({6'd0, r_cnt[0]} + {6'd0, r_cnt[1]}));
        w_round = r_acc + (r_48 ? (128'd1 << 47) : (128'd1 << 31));
        w_q     = r_48 ? (w_round >> 48) : (w_round >> 32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_ua   <= magnitude(i_req.a);
                r_ub   <= magnitude(i_req.b);
                r_neg  <= i_req.a[63] ^ i_req.b[63];
                r_48   <= i_req.sh48;
                r_acc  <= 128'd0;
                r_cnt  <= 3'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == 3'd4) begin
                    r_res  <= from_mag(|w_q[127:64], w_q[63:0], r_neg);
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_acc <= r_acc + w_part;
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule

// ===== sv/ckf_div.sv =====
// Shared divider: restoring division of n * 2^48 by a positive d, one quotient bit per cycle.
module ckf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ckf_pkg::t_div_req  i_req,
    output logic               o_done,
    output logic signed [63:0] o_result
);
    import ckf_pkg::*;

    localparam int STEPS = 112;
    localparam int CW    = $clog2(STEPS + 1);

    logic [63:0]     r_rem, r_d;
    logic [STEPS-1:0] r_num;
    logic            r_neg, r_busy, r_fin, r_done;
    logic [CW-1:0]   r_cnt;
    logic signed [63:0] r_res;

    logic [63:0] w_sh;
    logic        w_ge;

    always_comb begin
        w_sh = {r_rem[62:0], r_num[STEPS-1]};
        w_ge = (w_sh >= r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= {magnitude(i_req.n), 48'd0};
                r_d    <= i_req.d;
                r_rem  <= 64'd0;
                r_neg  <= i_req.n[63];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_sh - r_d) : w_sh;
                r_num <= {r_num[STEPS-2:0], w_ge};
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (r_fin) begin
                r_res  <= from_mag(|r_num[STEPS-1:64], r_num[63:0], r_neg);
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule

// ===== sv/clock_offset_skew_kalman.sv =====
// Top level of the clock offset and skew Kalman filter with its step sequencer.
// Usage: requests enter on the input channel (i_in_valid / o_in_stall) as an update
// pair, a query or a clear; each produces one result on the output channel
// (o_out_valid / i_out_stall) carrying status, estimated local time, offset and skew.
// Configuration registers are written on the cfg channel, always ready; the user must
// write them only while idle, the block itself does not enforce it. One request is
// processed at a time; o_in_stall is high from acceptance until the result is taken.
// A clear or a seeding update answers in the cycle after acceptance. A full update
// runs eleven products on the shared multiplier plus two gain divisions on the shared
// divider (one quotient bit per cycle), with saturating adds between them. When the
// innovation variance is not positive the divisions are left out. An update whose
// interval is below the minimum is skipped and answers after the interval check.
// Request code three is dropped with no result.
// Reset clears the filter state and restores the register defaults.
// While the receiver stalls, the result is held steady and no new request is taken.
module clock_offset_skew_kalman (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ckf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ckf_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [62:0]   i_cfg_data
);
    import ckf_pkg::*;

    t_state r_state, n_state;
    t_step  r_step, n_step;

    logic [62:0] r_iov, r_isv, r_snv, r_mv, r_min;
    logic        r_init;
    logic signed [63:0] r_off, r_skw, r_p00, r_p01, r_p10, r_p11, r_last;
    logic signed [63:0] r_dt, r_q00, r_q01, r_q10, r_q11, r_s, r_k0, r_k1, r_r, r_tmp;
    logic signed [63:0] r_est;
    logic [1:0]  r_req;
    logic signed [63:0] r_dev, r_loc;
    logic [2:0]  r_status;

    t_kind    w_kind;
    t_mul_req w_mreq;
    t_div_req w_dreq;
    logic     w_mdone, w_ddone, w_done, w_finish, w_accept, w_too_soon, w_spos;
    logic signed [63:0] w_mres, w_dres, w_u, w_s;

    ckf_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_mreq),
                   .o_done(w_mdone), .o_result(w_mres));
    ckf_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq),
                   .o_done(w_ddone), .o_result(w_dres));

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_too_soon = r_dt < $signed({1'b0, r_min});
    // The gain branch is chosen on the innovation variance formed in this step.
    assign w_s        = sat_addsub(r_q00, {1'b0, r_mv}, 1'b0);
    assign w_spos     = !w_s[63] && (w_s != 64'sd0);

    always_comb begin
        w_kind       = K_NONE;
        w_mreq.a     = r_dt;
        w_mreq.b     = r_skw;
        w_mreq.sh48  = 1'b1;
        w_dreq.n     = r_q00;
        w_dreq.d     = r_s;
        case (r_step)
            SP_OFFP:  w_kind = K_MUL;
            SP_Q01:   begin w_kind = K_MUL; w_mreq.b = r_p11; w_mreq.sh48 = 1'b0; end
            SP_Q00A:  begin w_kind = K_MUL; w_mreq.b = r_p10; w_mreq.sh48 = 1'b0; end
            SP_Q00B:  begin w_kind = K_MUL; w_mreq.b = r_q01; w_mreq.sh48 = 1'b0; end
            SP_Q11:   begin
                w_kind = K_MUL; w_mreq.b = {1'b0, r_snv}; w_mreq.sh48 = 1'b0;
            end
            SP_K0:    w_kind = K_DIV;
            SP_K1:    begin w_kind = K_DIV; w_dreq.n = r_q10; end
            SP_OFFU:  begin w_kind = K_MUL; w_mreq.a = r_k0; w_mreq.b = r_r; end
            SP_SKW:   begin
                w_kind = K_MUL; w_mreq.a = r_k1; w_mreq.b = r_r; w_mreq.sh48 = 1'b0;
            end
            SP_P00:   begin w_kind = K_MUL; w_mreq.a = r_k0; w_mreq.b = r_q00; end
            SP_P01:   begin w_kind = K_MUL; w_mreq.a = r_k0; w_mreq.b = r_q01; end
            SP_P10:   begin w_kind = K_MUL; w_mreq.a = r_k1; w_mreq.b = r_q00; end
            SP_P11:   begin w_kind = K_MUL; w_mreq.a = r_k1; w_mreq.b = r_q01; end
            SP_QEST0: w_kind = K_MUL;
            default:  w_kind = K_NONE;
        endcase
        w_mreq.start = (r_state == S_EXEC) && (w_kind == K_MUL);
        w_dreq.start = (r_state == S_EXEC) && (w_kind == K_DIV);
        w_u    = (w_kind == K_DIV) ? w_dres : w_mres;
        w_done = ((r_state == S_EXEC) && (w_kind == K_NONE)) ||
                 ((r_state == S_WAIT) && (((w_kind == K_MUL) && w_mdone) ||
                                          ((w_kind == K_DIV) && w_ddone)));

        n_step   = r_step;
        w_finish = 1'b0;
        case (r_step)
            SP_DT:    n_step = (r_req == REQ_UPDATE) ? SP_CHK : SP_QEST0;
            SP_CHK:   begin n_step = SP_OFFP; w_finish = w_too_soon; end
            SP_OFFP:  n_step = SP_Q01;
            SP_Q01:   n_step = SP_Q00A;
            SP_Q00A:  n_step = SP_Q00B;
            SP_Q00B:  n_step = SP_Q11;
            SP_Q11:   n_step = SP_S;
            SP_S:     n_step = w_spos ? SP_K0 : SP_R0;
            SP_K0:    n_step = SP_K1;
            SP_K1:    n_step = SP_R0;
            SP_R0:    n_step = SP_R1;
            SP_R1:    n_step = SP_OFFU;
            SP_OFFU:  n_step = SP_SKW;
            SP_SKW:   n_step = SP_P00;
            SP_P00:   n_step = SP_P01;
            SP_P01:   n_step = SP_P10;
            SP_P10:   n_step = SP_P11;
            SP_P11:   begin n_step = SP_DT; w_finish = 1'b1; end
            SP_QEST0: n_step = SP_QEST1;
            SP_QEST1: begin n_step = SP_DT; w_finish = 1'b1; end
            default:  n_step = SP_DT;
        endcase

        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_data.req_type)
                        REQ_CLEAR:  n_state = S_OUT;
                        REQ_UPDATE: n_state = r_init ? S_EXEC : S_OUT;
                        REQ_QUERY:  n_state = S_EXEC;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_EXEC: begin
                if (w_kind != K_NONE) begin
                    n_state = S_WAIT;
                end else if (w_finish) begin
                    n_state = S_OUT;
                end
            end
            S_WAIT: begin
                if (w_done) begin
                    n_state = w_finish ? S_OUT : S_EXEC;
                end
            end
            S_OUT:   if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= SP_DT;
            r_iov   <= 63'd281474976710656;
            r_isv   <= 63'd281474977;
            r_snv   <= 63'd281;
            r_mv    <= 63'd28147497671;
            r_min   <= 63'd0;
            r_init  <= 1'b0;
            r_off   <= '0;
            r_skw   <= '0;
            r_p00   <= '0;
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_INIT_OFF_VAR: r_iov <= i_cfg_data;
                    CFG_INIT_SKW_VAR: r_isv <= i_cfg_data;
                    CFG_SKW_NOISE:    r_snv <= i_cfg_data;
                    CFG_MEAS_VAR:     r_mv  <= i_cfg_data;
                    CFG_MIN_INTERVAL: r_min <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_req  <= i_in_data.req_type;
                r_dev  <= i_in_data.dev_ts;
                r_loc  <= i_in_data.loc_ts;
                r_est  <= '0;
                r_step <= SP_DT;
                if (i_in_data.req_type == REQ_CLEAR) begin
                    r_init   <= 1'b0;
                    r_status <= STAT_CLEAR;
                end else if (!r_init && (i_in_data.req_type != REQ_UNUSED)) begin
                    // Seed the filter from this pair.
                    r_off    <= sat_addsub(i_in_data.loc_ts, i_in_data.dev_ts, 1'b1);
                    r_skw    <= '0;
                    r_p00    <= {1'b0, r_iov};
                    r_p01    <= '0;
                    r_p10    <= '0;
                    r_p11    <= {1'b0, r_isv};
                    r_last   <= i_in_data.dev_ts;
                    r_init   <= 1'b1;
                    r_status <= STAT_INIT;
                end
            end
            if (w_done) begin
                r_step <= n_step;
                case (r_step)
                    SP_DT:   r_dt <= sat_addsub(r_dev, r_last, 1'b1);
                    SP_CHK:  if (w_too_soon) r_status <= STAT_SKIP;
                    SP_OFFP: r_off <= sat_addsub(r_off, w_u, 1'b0);
                    SP_Q01: begin
                        r_q01 <= sat_addsub(r_p01, w_u, 1'b0);
                        r_q10 <= sat_addsub(r_p10, w_u, 1'b0);
                    end
                    SP_Q00A: r_q00 <= sat_addsub(r_p00, w_u, 1'b0);
                    SP_Q00B: r_q00 <= sat_addsub(r_q00, w_u, 1'b0);
                    SP_Q11:  r_q11 <= sat_addsub(r_p11, w_u, 1'b0);
                    SP_S: begin
                        r_s  <= w_s;
                        r_k0 <= '0;
                        r_k1 <= '0;
                    end
                    SP_K0:   r_k0 <= w_u;
                    SP_K1:   r_k1 <= w_u;
                    SP_R0:   r_r <= sat_addsub(r_loc, r_dev, 1'b1);
                    SP_R1:   r_r <= sat_addsub(r_r, r_off, 1'b1);
                    SP_OFFU: r_off <= sat_addsub(r_off, w_u, 1'b0);
                    SP_SKW:  r_skw <= sat_addsub(r_skw, w_u, 1'b0);
                    SP_P00:  r_p00 <= sat_addsub(r_q00, w_u, 1'b1);
                    SP_P01:  r_p01 <= sat_addsub(r_q01, w_u, 1'b1);
                    SP_P10:  r_p10 <= sat_addsub(r_q10, w_u, 1'b1);
                    SP_P11: begin
                        r_p11    <= sat_addsub(r_q11, w_u, 1'b1);
                        r_last   <= r_dev;
                        r_status <= STAT_UPD;
                    end
                    SP_QEST0: begin
                        r_tmp <= w_u;
                        r_est <= sat_addsub(r_dev, r_off, 1'b0);
                    end
                    SP_QEST1: begin
                        r_est    <= sat_addsub(r_est, r_tmp, 1'b0);
                        r_status <= STAT_QUERY;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;
    assign o_out_data.status    = r_status;
    assign o_out_data.est_local = r_est;
    assign o_out_data.offset    = r_off;
    assign o_out_data.skew      = r_skw;
endmodule

// ===== sv/ckf_chk.sv =====
// Port-level checker for the clock Kalman filter, bound to the top level.
module ckf_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input ckf_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ckf_pkg::t_out o_out_data
);
    import ckf_pkg::*;

    // A pending result keeps the input side closed.
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // Any accepted request other than the unused code is followed by a closed input.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.req_type != REQ_UNUSED)) |=> o_in_stall)
        else $error("input open right after a request");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result changed under stall");
endmodule

bind clock_offset_skew_kalman ckf_chk u_ckf_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .i_in_data(i_in_data), .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
    .o_out_data(o_out_data)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the clock offset and skew Kalman filter.
`timescale 1ns / 100ps

module tb_top;
    import ckf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [62:0] i_cfg_data;

    clock_offset_skew_kalman uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    typedef struct {
        t_in  req;
        logic pinned;
        t_out res;
    } t_row;

    // Filter state mirrored by the predictor.
    logic               flt_locked;
    logic signed [63:0] flt_off, flt_skw, flt_last;
    logic signed [63:0] flt_cov [4];
    logic [62:0]        reg_off_var, reg_skw_var, reg_skw_noise, reg_meas_var, reg_min_gap;

    t_out  pending_results [$];
    t_row  directed_rows [$];
    int    err_count;
    int    snd_idle_pct, rcv_idle_pct;
    logic  pin_on;
    t_out  pin_res;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sub_sat(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
        return s[63:0];
    endfunction

    // Magnitude to signed, saturating; a negative magnitude of exactly 2^63 gives the minimum.
    function automatic logic signed [63:0] signed_of(logic [127:0] m, logic neg);
        if (m > 128'h7FFF_FFFF_FFFF_FFFF) return neg ? S64_MIN : S64_MAX;
        return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
    endfunction

    function automatic logic [127:0] abs128(logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? (64'd0 - v) : v;
        return {64'd0, m};
    endfunction

    // Product rounded to nearest (ties away from zero) after a right shift.
    function automatic logic signed [63:0] prod_round(logic signed [63:0] a,
                                                      logic signed [63:0] b, int sh);
        logic [127:0] ua, ub, p;
        logic neg;
        ua = abs128(a);
        ub = abs128(b);
        neg = (a[63] != b[63]) && ua != 0 && ub != 0;
        p = ((ua * ub) + (128'd1 << (sh - 1))) >> sh;
        return signed_of(p, neg);
    endfunction

    function automatic logic signed [63:0] gain_div(logic signed [63:0] n, logic signed [63:0] d);
        logic [127:0] q;
        q = (abs128(n) << 48) / 128'(d);
        return signed_of(q, n[63] && q != 0);
    endfunction

    task automatic seed_filter(logic signed [63:0] dev, logic signed [63:0] loc);
        flt_off = sub_sat(loc, dev);
        flt_skw = 0;
        flt_cov[0] = 64'(reg_off_var);
        flt_cov[1] = 0;
        flt_cov[2] = 0;
        flt_cov[3] = 64'(reg_skw_var);
        flt_last = dev;
        flt_locked = 1'b1;
    endtask

    task automatic filter_step(logic signed [63:0] dt, logic signed [63:0] dev,
                               logic signed [63:0] loc);
        logic signed [63:0] q00, q01, q10, q11, s, k0, k1, r;
        flt_off = add_sat(flt_off, prod_round(dt, flt_skw, 48));
        q01 = add_sat(flt_cov[1], prod_round(dt, flt_cov[3], 32));
        q10 = add_sat(flt_cov[2], prod_round(dt, flt_cov[3], 32));
        q00 = add_sat(add_sat(flt_cov[0], prod_round(dt, flt_cov[2], 32)),
                      prod_round(dt, q01, 32));
        q11 = add_sat(flt_cov[3], prod_round(dt, 64'(reg_skw_noise), 32));
        s = add_sat(q00, 64'(reg_meas_var));
        k0 = 0;
        k1 = 0;
        if (s > 0) begin
            k0 = gain_div(q00, s);
            k1 = gain_div(q10, s);
        end
        r = sub_sat(sub_sat(loc, dev), flt_off);
        flt_off = add_sat(flt_off, prod_round(k0, r, 48));
        flt_skw = add_sat(flt_skw, prod_round(k1, r, 32));
        flt_cov[0] = sub_sat(q00, prod_round(k0, q00, 48));
        flt_cov[1] = sub_sat(q01, prod_round(k0, q01, 48));
        flt_cov[2] = sub_sat(q10, prod_round(k1, q00, 48));
        flt_cov[3] = sub_sat(q11, prod_round(k1, q01, 48));
        flt_last = dev;
    endtask

    // Advances the mirrored filter by one request; has is low for the unused code.
    task automatic predict_filter(t_in rq, output logic has, output t_out res);
        logic signed [63:0] dt;
        has = 1'b1;
        res = '0;
        case (rq.req_type)
            REQ_UPDATE: begin
                if (!flt_locked) begin
                    seed_filter(rq.dev_ts, rq.loc_ts);
                    res.status = STAT_INIT;
                end else begin
                    dt = sub_sat(rq.dev_ts, flt_last);
                    if (dt < $signed({1'b0, reg_min_gap})) begin
                        res.status = STAT_SKIP;
                    end else begin
                        filter_step(dt, rq.dev_ts, rq.loc_ts);
                        res.status = STAT_UPD;
                    end
                end
            end
            REQ_QUERY: begin
                if (!flt_locked) seed_filter(rq.dev_ts, rq.loc_ts);
                dt = sub_sat(rq.dev_ts, flt_last);
                res.est_local = add_sat(add_sat(rq.dev_ts, flt_off),
                                        prod_round(dt, flt_skw, 48));
                res.status = STAT_QUERY;
            end
            REQ_CLEAR: begin
                flt_locked = 1'b0;
                res.status = STAT_CLEAR;
            end
            default: has = 1'b0;
        endcase
        res.offset = flt_off;
        res.skew = flt_skw;
    endtask

    // Accepted requests and register writes feed the predictor.
    always @(posedge i_clk) begin
        logic has;
        t_out res;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_filter(i_in_data, has, res);
            if (has) pending_results.push_back(pin_on ? pin_res : res);
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_INIT_OFF_VAR: reg_off_var = i_cfg_data;
                CFG_INIT_SKW_VAR: reg_skw_var = i_cfg_data;
                CFG_SKW_NOISE:    reg_skw_noise = i_cfg_data;
                CFG_MEAS_VAR:     reg_meas_var = i_cfg_data;
                CFG_MIN_INTERVAL: reg_min_gap = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Result side: compare and apply random back-pressure.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out_data);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             o_out_data.status);
                    err_count++;
                end
                if (o_out_data.est_local !== want.est_local) begin
                    $display("%0t: estimate expected %h got %h", $time,
                             want.est_local, o_out_data.est_local);
                    err_count++;
                end
                if (o_out_data.offset !== want.offset) begin
                    $display("%0t: offset expected %h got %h", $time, want.offset,
                             o_out_data.offset);
                    err_count++;
                end
                if (o_out_data.skew !== want.skew) begin
                    $display("%0t: skew expected %h got %h", $time, want.skew,
                             o_out_data.skew);
                    err_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    task automatic send_request(t_in rq);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= rq;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Lets every outstanding result drain, plus slack for a dropped request.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [62:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_row(logic [1:0] rt, logic signed [63:0] dev, logic signed [63:0] loc,
                           logic pinned, logic [2:0] st, logic signed [63:0] est,
                           logic signed [63:0] off);
        t_row row;
        row.req = '{req_type: rt, dev_ts: dev, loc_ts: loc};
        row.pinned = pinned;
        row.res = '{status: st, est_local: est, offset: off, skew: 64'sd0};
        directed_rows.push_back(row);
    endtask

    // Random phase: mostly well-formed update streams around a drifting clock.
    task automatic random_phase(int count);
        logic signed [63:0] dev, true_off, loc;
        int pick;
        t_in rq;
        dev = $signed(rand64()) >>> $urandom_range(2, 40);
        true_off = $signed(rand64()) >>> $urandom_range(4, 40);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            true_off = true_off + ($signed(64'($urandom_range(2000))) - 64'sd1000) * 64'sd4096;
            if (pick < 72) begin
                if ($urandom_range(19) == 0) dev = dev - 64'($urandom_range(1 << 30));
                else dev = dev + 64'($urandom()) + (64'($urandom_range(3)) << 32);
                loc = dev + true_off + $signed(64'($urandom_range(1 << 20))) - 64'sd524288;
                rq = '{req_type: REQ_UPDATE, dev_ts: dev, loc_ts: loc};
            end else if (pick < 84) begin
                rq = '{req_type: REQ_QUERY,
                       dev_ts: dev + $signed(64'($urandom())) - 64'sd2147483648,
                       loc_ts: dev + true_off};
            end else if (pick < 89) begin
                rq = '{req_type: REQ_CLEAR, dev_ts: rand64(), loc_ts: rand64()};
            end else if (pick < 91) begin
                rq = '{req_type: REQ_UNUSED, dev_ts: rand64(), loc_ts: rand64()};
            end else begin
                rq = '{req_type: 2'($urandom_range(3)), dev_ts: rand64(),
                       loc_ts: rand64()};
            end
            send_request(rq);
            // Once per phase hold off until the filter has answered everything.
            if (i == count / 2) drain_results();
        end
    endtask

    initial begin
        err_count = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        pin_on = 1'b0;
        pin_res = '0;
        flt_locked = 1'b0;
        flt_off = 0;
        flt_skw = 0;
        flt_last = 0;
        for (int k = 0; k < 4; k++) flt_cov[k] = 0;
        reg_off_var = 63'd281474976710656;
        reg_skw_var = 63'd281474977;
        reg_skw_noise = 63'd281;
        reg_meas_var = 63'd28147497671;
        reg_min_gap = 63'd0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_INIT_OFF_VAR;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(REQ_CLEAR, 0, 0, 1, STAT_CLEAR, 0, 0);
        // Uninitialized query seeds from the supplied local time.
        add_row(REQ_QUERY, S64_MAX, S64_MIN, 1, STAT_QUERY, -64'sd1, S64_MIN);
        add_row(REQ_CLEAR, 0, 0, 1, STAT_CLEAR, 0, S64_MIN);
        add_row(REQ_UPDATE, 0, 64'sd5 <<< 32, 1, STAT_INIT, 0, 64'sd5 <<< 32);
        add_row(REQ_QUERY, 0, 0, 1, STAT_QUERY, 64'sd5 <<< 32, 64'sd5 <<< 32);
        add_row(REQ_UPDATE, 64'sd1 <<< 32, (64'sd6 <<< 32) + 64'sd9999, 0, 0, 0, 0);
        add_row(REQ_UPDATE, 0, 0, 0, 0, 0, 0);
        add_row(REQ_UNUSED, S64_MAX, S64_MAX, 0, 0, 0, 0);
        add_row(REQ_UPDATE, 64'sd2 <<< 32, (64'sd7 <<< 32) - 64'sd12345, 0, 0, 0, 0);
        add_row(REQ_QUERY, S64_MIN, 0, 0, 0, 0, 0);
        add_row(REQ_UPDATE, S64_MAX, S64_MIN, 0, 0, 0, 0);
        add_row(REQ_UPDATE, S64_MIN, S64_MAX, 0, 0, 0, 0);
        add_row(REQ_QUERY, S64_MAX, -64'sd1, 0, 0, 0, 0);
        add_row(REQ_CLEAR, -64'sd1, -64'sd1, 0, 0, 0, 0);
        add_row(REQ_UPDATE, S64_MIN, S64_MAX, 1, STAT_INIT, 0, S64_MAX);
        add_row(REQ_UPDATE, -64'sd1, -64'sd1, 0, 0, 0, 0);
        add_row(REQ_QUERY, 64'sd3 <<< 32, 64'sd1, 0, 0, 0, 0);
        // The pinned expectation changes with the request, after the accepting edge.
        foreach (directed_rows[i]) begin
            pin_on <= directed_rows[i].pinned;
            pin_res <= directed_rows[i].res;
            send_request(directed_rows[i].req);
        end
        pin_on <= 1'b0;

        // Typical tuning, receiver stalls often.
        snd_idle_pct = 30;
        rcv_idle_pct = 76;
        drain_results();
        write_reg(CFG_INIT_OFF_VAR, 63'($urandom()) << 20);
        write_reg(CFG_INIT_SKW_VAR, 63'($urandom()));
        write_reg(CFG_SKW_NOISE, 63'($urandom_range(100000)));
        write_reg(CFG_MEAS_VAR, 63'($urandom()) << 4);
        write_reg(CFG_MIN_INTERVAL, 63'($urandom_range(1 << 30)));
        random_phase(500);

        // All variances zero: after a reseed the innovation variance is not positive.
        snd_idle_pct = 76;
        rcv_idle_pct = 30;
        drain_results();
        write_reg(CFG_INIT_OFF_VAR, 63'd0);
        write_reg(CFG_INIT_SKW_VAR, 63'd0);
        write_reg(CFG_SKW_NOISE, 63'd0);
        write_reg(CFG_MEAS_VAR, 63'd0);
        write_reg(CFG_MIN_INTERVAL, 63'd0);
        random_phase(500);

        // Largest register values drive the arithmetic into saturation.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        drain_results();
        write_reg(CFG_INIT_OFF_VAR, '1);
        write_reg(CFG_INIT_SKW_VAR, '1);
        write_reg(CFG_SKW_NOISE, '1);
        write_reg(CFG_MEAS_VAR, '1);
        write_reg(CFG_MIN_INTERVAL, '1);
        random_phase(150);
        drain_results();
        write_reg(CFG_INIT_OFF_VAR, 63'd281474976710656);
        write_reg(CFG_INIT_SKW_VAR, 63'd281474977);
        write_reg(CFG_SKW_NOISE, 63'd281);
        write_reg(CFG_MEAS_VAR, 63'd28147497671);
        write_reg(CFG_MIN_INTERVAL, 63'd0);
        random_phase(350);

        drain_results();
        repeat (400) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
